// ===== design/pcs_pkg.sv =====
// Shared types, codes and constant tables for the patch record stream checker.
package pcs_pkg;

  // Fixed layout of the patch header
  localparam int HEADER_BYTES = 80;
  localparam int MAGIC_END    = 8;
  localparam int SIZE_END     = 16;
  localparam int ADDR_W       = 20;
  localparam int POS_W        = 7;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = 1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RECHDR = 2'd1,
    PH_DATA   = 2'd2,
    PH_END    = 2'd3
  } ph_t;

  typedef enum logic [2:0] {
    ST_RUN    = 3'd0,
    ST_OK     = 3'd1,
    ST_BADHDR = 3'd2,
    ST_BADREC = 3'd3,
    ST_TRUNC  = 3'd4,
    ST_TRAIL  = 3'd5
  } st_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_data;
    logic              done_res;
    st_t               status;
  } res_t;

  // Handshake status of the two queues seen by the parser
  typedef struct packed {
    logic in_empty;
    logic out_full;
  } q_stat_t;

  localparam logic [7:0] MAGIC_TAB [MAGIC_END] = '{
    8'h42, 8'h53, 8'h44, 8'h45, 8'h4c, 8'h58, 8'h31, 8'h00
  };

  localparam logic [7:0] DIGEST_TAB [64] = '{
    8'hbf, 8'h16, 8'hc3, 8'hc8, 8'h67, 8'hc5, 8'h8e, 8'h2a,
    8'hb0, 8'h61, 8'hc7, 8'h0d, 8'he9, 8'h29, 8'h5b, 8'h69,
    8'h30, 8'hd6, 8'h3f, 8'h29, 8'hf8, 8'h1c, 8'hc9, 8'h86,
    8'hf5, 8'hec, 8'hae, 8'h03, 8'he0, 8'had, 8'h18, 8'hd2,
    8'h55, 8'h21, 8'h59, 8'ha1, 8'h99, 8'h55, 8'he8, 8'h8a,
    8'h83, 8'h37, 8'hf7, 8'hc4, 8'h73, 8'hcc, 8'hc5, 8'h3e,
    8'h5d, 8'hce, 8'hf1, 8'h5b, 8'h87, 8'hda, 8'hab, 8'h8e,
    8'h89, 8'he1, 8'h89, 8'h46, 8'h94, 8'h54, 8'h2f, 8'he6
  };

endpackage

// ===== design/pcs_fifo.sv =====
// Two-entry request queue used on both sides of the parser.
module pcs_fifo
  import pcs_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0]  mem_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QDEPTH-1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QDEPTH-1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule

// ===== design/pcs_parse.sv =====
// Header and record parser: one byte in, one result out per cycle while go.
module pcs_parse
  import pcs_pkg::*;
#(
  parameter int IMAGE_BYTES = 1048576
) (
  input  logic     clk,
  input  logic     rst_n,
  input  q_stat_t  qs,
  input  in_item_t in_item,
  output logic     go,
  output res_t     res
);

  localparam int CNT_W = $clog2(IMAGE_BYTES + 1);
  localparam logic [31:0] IMG32 = 32'(IMAGE_BYTES);

  ph_t               ph_r, ph_step;
  st_t               err_r, err_step;
  logic [POS_W-1:0]  pos_r, pos_step;
  logic [CNT_W-1:0]  rl_r, rl_step;
  logic [CNT_W-1:0]  rbl_r, rbl_step;
  logic [CNT_W-1:0]  prev_r, prev_step;
  logic [ADDR_W-1:0] addr_r, addr_step;
  logic [55:0]       sh_r;
  logic [63:0]       word;
  logic [31:0]       f_lo, f_hi;
  logic [32:0]       rec_end;
  logic [7:0]        b;
  logic [5:0]        dig_idx;
  logic              rec_bad, hdr_bad;

  assign go      = !qs.in_empty && !qs.out_full;
  assign b       = in_item.data_byte;
  assign word    = {b, sh_r};
  assign f_lo    = word[31:0];
  assign f_hi    = word[63:32];
  assign rec_end = {1'b0, f_lo} + {1'b0, f_hi};
  assign dig_idx = 6'(pos_r - POS_W'(SIZE_END));
  assign hdr_bad = (f_lo != IMG32) || (f_hi == '0) || (f_hi > IMG32);
  assign rec_bad = (f_hi == '0) || (f_lo < 32'(prev_r)) || (f_lo >= IMG32) ||
                   (rec_end > 33'(IMAGE_BYTES));

  // Next state for one parsed byte, before the end-of-payload return to reset
  always_comb begin
    ph_step   = ph_r;
    err_step  = err_r;
    pos_step  = pos_r;
    rl_step   = rl_r;
    rbl_step  = rbl_r;
    prev_step = prev_r;
    addr_step = addr_r;
    if (err_r == ST_RUN) begin
      unique case (ph_r)
        PH_HEADER: begin
          if (pos_r < POS_W'(MAGIC_END)) begin
            if (b != MAGIC_TAB[pos_r[2:0]]) err_step = ST_BADHDR;
          end else if (pos_r < POS_W'(SIZE_END)) begin
            if (pos_r == POS_W'(SIZE_END-1)) begin
              if (hdr_bad) err_step = ST_BADHDR;
              else         rl_step  = f_hi[CNT_W-1:0];
            end
          end else begin
            if (b != DIGEST_TAB[dig_idx]) err_step = ST_BADHDR;
          end
          if (pos_r == POS_W'(HEADER_BYTES-1)) begin
            pos_step = '0;
            ph_step  = PH_RECHDR;
          end else begin
            pos_step = pos_r + 1'b1;
          end
        end
        PH_RECHDR: begin
          if (pos_r[2:0] == 3'd7) begin
            pos_step = '0;
            if (rec_bad) begin
              err_step = ST_BADREC;
            end else begin
              addr_step = f_lo[ADDR_W-1:0];
              rbl_step  = f_hi[CNT_W-1:0];
              prev_step = rec_end[CNT_W-1:0];
              ph_step   = PH_DATA;
            end
          end else begin
            pos_step = POS_W'(pos_r[2:0]) + 1'b1;
          end
        end
        PH_DATA: begin
          addr_step = addr_r + 1'b1;
          if (rbl_r != '0) rbl_step = rbl_r - 1'b1;
          if (rbl_r <= CNT_W'(1)) begin
            if (rl_r != '0) rl_step = rl_r - 1'b1;
            ph_step = (rl_r <= CNT_W'(1)) ? PH_END : PH_RECHDR;
          end
        end
        PH_END: begin
          err_step = ST_TRAIL;
        end
        default: begin
          err_step = ST_TRAIL;
        end
      endcase
    end
  end

  // Result for the byte being parsed
  always_comb begin
    res = '0;
    res.write_valid = (err_r == ST_RUN) && (ph_r == PH_DATA);
    if (res.write_valid) begin
      res.write_address = addr_r;
      res.write_data    = b;
    end
    res.done_res = in_item.is_last;
    res.status   = err_step;
    if (in_item.is_last && (err_step == ST_RUN)) begin
      res.status = (ph_step == PH_END) ? ST_OK : ST_TRUNC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && in_item.is_last)) begin
      ph_r   <= PH_HEADER;
      err_r  <= ST_RUN;
      pos_r  <= '0;
      rl_r   <= '0;
      rbl_r  <= '0;
      prev_r <= '0;
      addr_r <= '0;
    end else if (go) begin
      ph_r   <= ph_step;
      err_r  <= err_step;
      pos_r  <= pos_step;
      rl_r   <= rl_step;
      rbl_r  <= rbl_step;
      prev_r <= prev_step;
      addr_r <= addr_step;
    end
  end

  // Field collector: the last seven bytes, oldest in the low bits
  always_ff @(posedge clk) begin
    if (go) begin
      sh_r <= word[63:8];
    end
  end

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_item.is_last |=> (ph_r == PH_HEADER) && (pos_r == '0) && (err_r == ST_RUN))
    else $error("payload end did not restart the parser");

  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_RUN) && !(go && in_item.is_last) |=> (err_r == $past(err_r)))
    else $error("latched error changed inside a payload");

  a_data_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_DATA) && (err_r == ST_RUN) |-> (rbl_r != '0) && (rl_r != '0))
    else $error("data phase with no bytes or records left");

  a_no_write_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    go && res.write_valid |-> (err_r == ST_RUN) && (prev_r != '0))
    else $error("image write issued outside a valid record");
`endif

endmodule

// ===== design/patch_record_stream_checker.sv =====
// Top level of the patch record stream checker: input queue, parser, result queue.
//
// Feeds a patch payload one byte per request (in_data_byte, in_is_last on the
// final byte) and returns one result per byte: an image write (out_write_valid,
// out_write_address, out_write_data) for every record data byte, plus out_done_res
// and out_status on the result of the final byte. The 80-byte header is checked
// for the magic, an image size of exactly IMAGE_BYTES, a record count from 1 to
// IMAGE_BYTES and the built-in source and target digests; each record (LE 32-bit
// offset, LE 32-bit length, then data) must have a nonzero length, start at or
// after the end of the previous record and fit in the image. The first error is
// held until the payload ends and suppresses all later writes; the consumer must
// drop earlier writes whenever the final status is not 1 (accepted). Status codes:
// 0 running, 1 accepted, 2 bad header, 3 bad record, 4 truncated, 5 trailing bytes.
// After the final byte the checker returns to its reset state and the next byte
// starts a new payload. Throughput is one byte per clock while a byte waits in the
// input queue and the result queue has room; a two-entry queue on each side lets
// producer and consumer stall independently. An accepted request passes through the
// input queue, the parser and the result queue before its result shows on the out_ ports.
module patch_record_stream_checker
  import pcs_pkg::*;
#(
  parameter int IMAGE_BYTES = 1048576
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input queue side
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_data_byte,
  input  logic              in_is_last,
  // Result queue side
  output logic              empty,
  input  logic              pop,
  output logic              out_write_valid,
  output logic [ADDR_W-1:0] out_write_address,
  output logic [7:0]        out_write_data,
  output logic              out_done_res,
  output logic [2:0]        out_status
);

  in_item_t in_req, in_head;
  res_t     res_new, res_head;
  q_stat_t  qs;
  logic     go;

  assign in_req.data_byte = in_data_byte;
  assign in_req.is_last   = in_is_last;

  // Front: hold accepted bytes until the parser takes them
  pcs_fifo #(
    .WIDTH($bits(in_item_t))
  ) u_in_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (in_req),
    .full      (full),
    .pop       (go),
    .pop_data  (in_head),
    .empty     (qs.in_empty)
  );

  // Parse one byte per cycle whenever a byte waits and the result queue has room
  pcs_parse #(
    .IMAGE_BYTES(IMAGE_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .qs      (qs),
    .in_item (in_head),
    .go      (go),
    .res     (res_new)
  );

  // Back: hold results until the consumer pops them
  pcs_fifo #(
    .WIDTH($bits(res_t))
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (go),
    .push_data (res_new),
    .full      (qs.out_full),
    .pop       (pop),
    .pop_data  (res_head),
    .empty     (empty)
  );

  assign out_write_valid   = res_head.write_valid;
  assign out_write_address = res_head.write_address;
  assign out_write_data    = res_head.write_data;
  assign out_done_res      = res_head.done_res;
  assign out_status        = res_head.status;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the patch record stream checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcs_pkg::*;

  localparam int          CLK_PERIOD   = 8;
  localparam int          RST_CYCLES   = 12;
  localparam logic [31:0] IMG          = 32'd1048576;
  localparam int          HDR_LEN      = 80;
  localparam int          RANDOM_BYTES = 300;
  localparam int          TAIL_CYCLES  = 8;
  localparam int          CYCLE_LIMIT  = 2000000;

  // Own copies of the magic and the digest table, so a bad package table shows up
  localparam logic [7:0] PATCH_MAGIC [8] = '{
    8'h42, 8'h53, 8'h44, 8'h45, 8'h4c, 8'h58, 8'h31, 8'h00
  };

  localparam logic [7:0] ROM_DIGESTS [64] = '{
    8'hbf, 8'h16, 8'hc3, 8'hc8, 8'h67, 8'hc5, 8'h8e, 8'h2a,
    8'hb0, 8'h61, 8'hc7, 8'h0d, 8'he9, 8'h29, 8'h5b, 8'h69,
    8'h30, 8'hd6, 8'h3f, 8'h29, 8'hf8, 8'h1c, 8'hc9, 8'h86,
    8'hf5, 8'hec, 8'hae, 8'h03, 8'he0, 8'had, 8'h18, 8'hd2,
    8'h55, 8'h21, 8'h59, 8'ha1, 8'h99, 8'h55, 8'he8, 8'h8a,
    8'h83, 8'h37, 8'hf7, 8'hc4, 8'h73, 8'hcc, 8'hc5, 8'h3e,
    8'h5d, 8'hce, 8'hf1, 8'h5b, 8'h87, 8'hda, 8'hab, 8'h8e,
    8'h89, 8'he1, 8'h89, 8'h46, 8'h94, 8'h54, 8'h2f, 8'he6
  };

  // One directed payload: header fields, up to two records, then damage applied to it.
  // bad_pos inverts one header byte (-1 leaves it alone), keep cuts the payload to that
  // many bytes (0 keeps it whole) and trail appends stray bytes after the last record.
  typedef struct packed {
    logic [31:0] img_size;
    logic [31:0] rec_count;
    int          n_rec;
    logic [31:0] off0;
    logic [31:0] len0;
    logic [31:0] off1;
    logic [31:0] len1;
    int          bad_pos;
    int          keep;
    int          trail;
    st_t         want;
  } plan_t;

  // The status on the final byte of each row is typed in; every other byte of a row
  // is held against the predictor. Rows that fail early end on the failing byte.
  localparam plan_t DIRECTED [23] = '{
    // size      count         n  off0         len0          off1  len1 bad keep trl want
    '{IMG,       32'd1,        1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 1,  0, ST_TRUNC},
    '{IMG,       32'd1,        1, 32'd0,       32'd1,        32'd0, 32'd0,  0, 1,  0, ST_BADHDR},
    '{IMG,       32'd1,        1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 0,  0, ST_OK},
    '{IMG,       32'd1,        1, IMG - 32'd1, 32'd1,        32'd0, 32'd0, -1, 0,  0, ST_OK},
    '{IMG,       32'd2,        2, 32'd0,       32'd2,        32'd2, 32'd3, -1, 0,  0, ST_OK},
    '{IMG,       32'd0,        1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 16, 0, ST_BADHDR},
    '{IMG,       IMG + 32'd1,  1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 16, 0, ST_BADHDR},
    '{IMG,       32'hffffffff, 1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 16, 0, ST_BADHDR},
    '{IMG - 32'd1, 32'd1,      1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 16, 0, ST_BADHDR},
    '{32'hffffffff, 32'd1,     1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 16, 0, ST_BADHDR},
    '{IMG,       32'd1,        1, 32'd0,       32'd1,        32'd0, 32'd0,  7, 8,  0, ST_BADHDR},
    '{IMG,       32'd1,        1, 32'd0,       32'd1,        32'd0, 32'd0, 79, 80, 0, ST_BADHDR},
    '{IMG,       IMG,          1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 0,  0, ST_TRUNC},
    '{IMG,       32'd1,        1, 32'd0,       32'd0,        32'd0, 32'd0, -1, 0,  0, ST_BADREC},
    '{IMG,       32'd2,        2, 32'd0,       32'd4,        32'd3, 32'd1, -1, 100, 0, ST_BADREC},
    '{IMG,       32'd1,        1, IMG,         32'd1,        32'd0, 32'd0, -1, 88, 0, ST_BADREC},
    '{IMG,       32'd1,        1, IMG - 32'd4, 32'd5,        32'd0, 32'd0, -1, 88, 0, ST_BADREC},
    '{IMG,       32'd1,        1, 32'd0,       32'hffffffff, 32'd0, 32'd0, -1, 88, 0, ST_BADREC},
    '{IMG,       32'd1,        1, 32'hffffffff, 32'd1,       32'd0, 32'd0, -1, 88, 0, ST_BADREC},
    '{IMG,       32'd1,        1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 0,  1, ST_TRAIL},
    '{IMG,       32'd1,        1, 32'd10,      32'd6,        32'd0, 32'd0, -1, 91, 0, ST_TRUNC},
    '{IMG,       32'd1,        1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 84, 0, ST_TRUNC},
    '{IMG,       32'd2,        1, 32'd0,       32'd1,        32'd0, 32'd0, -1, 0,  0, ST_TRUNC}
  };

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              push         = 1'b0;
  logic              pop          = 1'b0;
  logic [7:0]        in_data_byte = '0;
  logic              in_is_last   = 1'b0;
  logic              full;
  logic              empty;
  logic              out_write_valid;
  logic [ADDR_W-1:0] out_write_address;
  logic [7:0]        out_write_data;
  logic              out_done_res;
  logic [2:0]        out_status;

  // Predictor state, mirrors the parser after every accepted byte
  ph_t         cur_phase;
  st_t         latched_err;
  int unsigned field_pos;
  logic [63:0] collect;
  logic [31:0] recs_to_go;
  logic [31:0] wr_ptr;
  logic [31:0] data_to_go;
  logic [31:0] last_end;

  logic [7:0]  pay_q [$];          // payload being assembled
  res_t        byte_results_due [$];
  res_t        oldest;
  int unsigned sent_bytes   = 0;   // bytes the block has accepted in the current part
  bit          quiet        = 1'b0; // no idling on either side while set
  bit          mismatch_seen = 1'b0;
  int          stall_left   = 0;
  int          cycles       = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  patch_record_stream_checker #(
    .IMAGE_BYTES(IMG)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_is_last        (in_is_last),
    .empty             (empty),
    .pop               (pop),
    .out_write_valid   (out_write_valid),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_done_res      (out_done_res),
    .out_status        (out_status)
  );

  // Mostly back to back, now and then a short pause, rarely a long one
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_model();
    cur_phase   = PH_HEADER;
    latched_err = ST_RUN;
    field_pos   = 0;
    collect     = '0;
    recs_to_go  = '0;
    wr_ptr      = '0;
    data_to_go  = '0;
    last_end    = '0;
  endtask

  // Advance the predictor by one payload byte and work out the result it causes
  task automatic model_patch_byte(input logic [7:0] b, input logic l, output res_t r);
    logic [31:0] f_off;
    logic [31:0] f_len;
    r = '0;
    // Once an error is latched, bytes are skipped: no parsing, no writes
    if (latched_err == ST_RUN) begin
      case (cur_phase)
        PH_HEADER: begin
          if (field_pos < 8) begin
            if (b != PATCH_MAGIC[field_pos]) latched_err = ST_BADHDR;
          end else if (field_pos < 16) begin
            // Image size then record count, both little-endian
            collect[8 * (field_pos - 8) +: 8] = b;
            if (field_pos == 15) begin
              if (collect[31:0] != IMG || collect[63:32] == 0 || collect[63:32] > IMG)
                latched_err = ST_BADHDR;
              else
                recs_to_go = collect[63:32];
              collect = '0;
            end
          end else if (b != ROM_DIGESTS[field_pos - 16]) begin
            latched_err = ST_BADHDR;
          end
          field_pos++;
          if (field_pos == HDR_LEN) begin
            field_pos = 0;
            cur_phase = PH_RECHDR;
          end
        end
        PH_RECHDR: begin
          collect[8 * field_pos +: 8] = b;
          field_pos++;
          if (field_pos == 8) begin
            f_off     = collect[31:0];
            f_len     = collect[63:32];
            field_pos = 0;
            collect   = '0;
            // Empty, overlapping, or running past the image end
            if (f_len == 0 || f_off < last_end || f_off >= IMG || f_len > IMG - f_off) begin
              latched_err = ST_BADREC;
            end else begin
              wr_ptr     = f_off;
              data_to_go = f_len;
              last_end   = f_off + f_len;
              cur_phase  = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          r.write_valid   = 1'b1;
          r.write_address = wr_ptr[ADDR_W-1:0];
          r.write_data    = b;
          wr_ptr++;
          if (data_to_go != 0) data_to_go--;
          if (data_to_go == 0) begin
            if (recs_to_go != 0) recs_to_go--;
            if (recs_to_go == 0) cur_phase = PH_END;
            else cur_phase = PH_RECHDR;
          end
        end
        default: begin
          // Anything after the last record is a stray byte
          latched_err = ST_TRAIL;
        end
      endcase
    end
    r.done_res = l;
    r.status   = latched_err;
    if (l && latched_err == ST_RUN) begin
      if (cur_phase == PH_END) r.status = ST_OK;
      else r.status = ST_TRUNC;
    end
    if (l) clear_model();
  endtask

  task automatic put_le32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) pay_q.push_back(v[8 * k +: 8]);
  endtask

  task automatic put_header(input logic [31:0] img_size, input logic [31:0] rec_count);
    foreach (PATCH_MAGIC[k]) pay_q.push_back(PATCH_MAGIC[k]);
    put_le32(img_size);
    put_le32(rec_count);
    foreach (ROM_DIGESTS[k]) pay_q.push_back(ROM_DIGESTS[k]);
  endtask

  // Record header plus random data; huge lengths get a few bytes only, as the
  // record is rejected before its data anyway
  task automatic put_record(input logic [31:0] off, input logic [31:0] len);
    put_le32(off);
    put_le32(len);
    repeat ((len > 16) ? 3 : len) pay_q.push_back(8'($urandom));
  endtask

  task automatic build_from_plan(input plan_t p);
    pay_q.delete();
    put_header(p.img_size, p.rec_count);
    if (p.n_rec >= 1) put_record(p.off0, p.len0);
    if (p.n_rec >= 2) put_record(p.off1, p.len1);
    if (p.bad_pos >= 0) pay_q[p.bad_pos] = ~pay_q[p.bad_pos];
    if (p.keep > 0) begin
      while (pay_q.size() > p.keep) void'(pay_q.pop_back());
    end
    repeat (p.trail) pay_q.push_back(8'($urandom));
  endtask

  // Mostly well-formed payloads with random placement and content; the rest are
  // noise, damaged headers, wrong counts, broken records, cut or overlong payloads
  task automatic build_random_payload();
    int unsigned roll;
    int unsigned nrec;
    int unsigned tot;
    int unsigned j;
    int unsigned cut;
    logic [31:0] offs [6];
    logic [31:0] lens [6];
    logic [31:0] cnt;
    logic [31:0] base;
    bit          at_top;
    pay_q.delete();
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      repeat ($urandom_range(1, 24)) pay_q.push_back(8'($urandom));
      return;
    end
    nrec   = $urandom_range(1, 6);
    at_top = ($urandom_range(0, 3) == 0);
    tot    = 0;
    for (int i = 0; i < nrec; i++) begin
      lens[i] = $urandom_range(1, 10);
      tot += lens[i];
    end
    // Either packed against the image end or scattered with small holes
    base = at_top ? IMG - tot : 32'($urandom_range(0, IMG - 4096));
    for (int i = 0; i < nrec; i++) begin
      if (!at_top && $urandom_range(0, 2) != 0) base += $urandom_range(1, 64);
      offs[i] = base;
      base += lens[i];
    end
    cnt = nrec;
    if (roll >= 75 && roll < 80) begin
      if (nrec > 1 && $urandom_range(0, 1) == 1) cnt = nrec - 1;
      else cnt = nrec + 1;
    end
    if (roll >= 80 && roll < 90) begin
      j = $urandom_range(0, nrec - 1);
      case ($urandom_range(0, 3))
        0: lens[j] = 0;
        1: begin
          if (j > 0) offs[j] = offs[j-1] + lens[j-1] - $urandom_range(1, lens[j-1]);
          else offs[j] = $urandom | IMG;
        end
        2: offs[j] = $urandom | IMG;
        default: begin
          if ($urandom_range(0, 1) == 1) lens[j] = IMG - offs[j] + $urandom_range(1, 8);
          else lens[j] = $urandom | IMG;
        end
      endcase
    end
    put_header(IMG, cnt);
    for (int i = 0; i < nrec; i++) put_record(offs[i], lens[i]);
    if (roll >= 65 && roll < 75) begin
      j = $urandom_range(0, HDR_LEN - 1);
      pay_q[j] = pay_q[j] ^ (8'h01 << $urandom_range(0, 7));
    end
    if (roll >= 90) begin
      if ($urandom_range(0, 1) == 1) begin
        cut = $urandom_range(1, pay_q.size() - 1);
        while (pay_q.size() > cut) void'(pay_q.pop_back());
      end else begin
        repeat ($urandom_range(1, 3)) pay_q.push_back(8'($urandom));
      end
    end
  endtask

  // Hold the request until it is taken, then predict its result
  task automatic send_byte(input logic [7:0] b, input logic l, input bit pin, input st_t pin_st);
    int   g;
    res_t r;
    g = gap_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
    push         <= 1'b1;
    in_data_byte <= b;
    in_is_last   <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_bytes++;
    model_patch_byte(b, l, r);
    if (pin) r.status = pin_st;
    byte_results_due.push_back(r);
  endtask

  task automatic send_payload(input bit pin, input st_t pin_st);
    for (int i = 0; i < pay_q.size(); i++)
      send_byte(pay_q[i], i == pay_q.size() - 1, pin && i == pay_q.size() - 1, pin_st);
  endtask

  // Drop the request line and wait for every outstanding result
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (byte_results_due.size() != 0);
  endtask

  // Result side: compare the oldest prediction on every pop, then pick the next pop
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (byte_results_due.size() == 0) begin
        $error("result popped with nothing predicted");
        mismatch_seen = 1'b1;
      end else begin
        oldest = byte_results_due.pop_front();
        if (out_write_valid !== oldest.write_valid) begin
          $error("write_valid: expected %0d, got %0d", oldest.write_valid, out_write_valid);
          mismatch_seen = 1'b1;
        end
        if (out_write_address !== oldest.write_address) begin
          $error("write_address: expected %h, got %h", oldest.write_address,
                 out_write_address);
          mismatch_seen = 1'b1;
        end
        if (out_write_data !== oldest.write_data) begin
          $error("write_data: expected %h, got %h", oldest.write_data, out_write_data);
          mismatch_seen = 1'b1;
        end
        if (out_done_res !== oldest.done_res) begin
          $error("done_res: expected %0d, got %0d", oldest.done_res, out_done_res);
          mismatch_seen = 1'b1;
        end
        if (out_status !== oldest.status) begin
          $error("status: expected %0d, got %0d", oldest.status, out_status);
          mismatch_seen = 1'b1;
        end
      end
    end
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 2) == 0) stall_left = gap_len();
    end
  end

  // Watchdog: far beyond the slowest legal run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    clear_model();
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed payloads: header and record rules at their edges
    for (int i = 0; i < $size(DIRECTED); i++) begin
      build_from_plan(DIRECTED[i]);
      send_payload(1'b1, DIRECTED[i].want);
    end
    drain();

    // Random payloads, with runs of no idling and the odd full drain in between
    sent_bytes = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 4) == 0);
      build_random_payload();
      send_payload(1'b0, ST_RUN);
      if ($urandom_range(0, 7) == 0) drain();
    end
    quiet = 1'b0;
    drain();

    // Let any stray result surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (!mismatch_seen) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
